>>> hw/rtl/uvs_pkg.sv
`default_nettype none
package uvs_pkg;

  localparam int MAX_GRID_DEF     = 256;
  localparam int CORDIC_STEPS_DEF = 16;

  // divider: quotient floor(x * 2^33 / d), x <= d < 512
  localparam int DIV_RW = 9;
  localparam int DIV_QW = 34;

  // CORDIC datapath, Q2.30 in a 34-bit signed word
  localparam int CW = 34;

  localparam logic signed [CW-1:0] CORDIC_K    = 34'sh026DD3B6A;
  localparam logic signed [31:0]   HALF_PI_Q30 = 32'sd1686629713;
  localparam logic [31:0]          QTR_OFFSET  = 32'h2000_0000;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_RINGS  = 2'd1;
  localparam logic [1:0] REG_SECTS  = 2'd2;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam int ATAN_LEN = 32;
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [15:0] quad_base;
    logic        quad_valid;
  } div_side_t;

  typedef struct packed {
    logic [15:0] quad_base;
    logic        quad_valid;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic [1:0]  q_th;
    logic [1:0]  q_ph;
  } side_t;

  // shift right with rounding half away from zero
  function automatic logic signed [67:0] shr_round(input logic signed [67:0] v,
                                                   input int unsigned sh);
    logic [67:0] mag;
    logic [67:0] half;
    mag  = v[67] ? 68'(-v) : 68'(v);
    half = 68'd1 << (sh - 1);
    mag  = (mag + half) >> sh;
    return v[67] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [67:0] sat(input logic signed [67:0] v,
                                             input logic signed [67:0] lo,
                                             input logic signed [67:0] hi);
    logic signed [67:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/uv_sphere_vertex_generator_unit.sv
// UV sphere vertex generator.
// Input channel: in_valid / in_stall with ring_index and sector_index. An item
// is taken on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with the normal (Q1.15), the position
// (Q9.8), texture u/v (Q1.15) and the quad base index with its valid flag.
// Config channel: cfg_valid / cfg_ready, cfg_index selects radius (0),
// ring count (1) or sector count (2); cfg_ready is always high. Write only
// while no item is in flight.
// Pipeline: one input register, 34 divider cells, one angle/multiply stage,
// the CORDIC cells, then quadrant map, product, normal, position product and
// output stages.
// Throughput: one item per cycle while the output is not stalled. The whole
// chain advances together; when the output register holds an item that is
// stalled, every stage holds and in_stall is raised, so nothing is dropped.
// Reset (rst, synchronous): all stage valids clear, radius = 1.0, both counts
// return to 16.
`default_nettype none
module uv_sphere_vertex_generator_unit import uvs_pkg::*; #(
  parameter int MAX_GRID     = MAX_GRID_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         ring_index,
  input  wire logic [7:0]         sector_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z,
  output logic signed [16:0]      pos_x,
  output logic signed [16:0]      pos_y,
  output logic signed [16:0]      pos_z,
  output logic [15:0]             tex_u,
  output logic [15:0]             tex_v,
  output logic [15:0]             quad_base,
  output logic                    quad_valid,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // ---------------- configuration ----------------
  logic [15:0] radius;
  logic [8:0]  ring_cnt;
  logic [8:0]  sect_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= 16'd256;
      ring_cnt <= 9'd16;
      sect_cnt <= 9'd16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIUS: radius   <= cfg_data;
        REG_RINGS:  ring_cnt <= cfg_data[8:0];
        REG_SECTS:  sect_cnt <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // counts clamped to [2, MAX_GRID]; d = count - 1 is the divisor
  logic [8:0] rc;
  logic [8:0] sc;
  logic [8:0] d_r;
  logic [8:0] d_s;

  always_comb begin
    rc = ring_cnt;
    if (ring_cnt < 9'd2) rc = 9'd2;
    else if (int'(ring_cnt) > MAX_GRID) rc = 9'(MAX_GRID);
    sc = sect_cnt;
    if (sect_cnt < 9'd2) sc = 9'd2;
    else if (int'(sect_cnt) > MAX_GRID) sc = 9'(MAX_GRID);
    d_r = rc - 9'd1;
    d_s = sc - 9'd1;
  end

  // ---------------- global advance ----------------
  // every stage moves when the output register is empty or being drained
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // ---------------- input stage ----------------
  logic [7:0] r_sat;
  logic [7:0] s_sat;
  logic       v_in;
  logic [7:0] r0;
  logic [7:0] s0;
  div_side_t  side0;
  div_side_t  side0_next;

  always_comb begin
    r_sat = ring_index;
    if ({1'b0, ring_index} > d_r) r_sat = d_r[7:0];
    s_sat = sector_index;
    if ({1'b0, sector_index} > d_s) s_sat = d_s[7:0];
    side0_next.quad_base  = 16'(({9'd0, r_sat} * {8'd0, sc}) + {9'd0, s_sat});
    side0_next.quad_valid = ({1'b0, r_sat} < d_r) && ({1'b0, s_sat} < d_s);
  end

  always_ff @(posedge clk) begin
    if (rst) v_in <= 1'b0;
    else if (adv) v_in <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0    <= r_sat;
      s0    <= s_sat;
      side0 <= side0_next;
    end
  end

  // ---------------- divider chains ----------------
  // F = floor(x * 2^33 / d), one quotient bit per cell
  logic [DIV_RW-1:0] rem_r [DIV_QW];
  logic [DIV_QW-1:0] quo_r [DIV_QW];
  logic [DIV_RW-1:0] rem_s [DIV_QW];
  logic [DIV_QW-1:0] quo_s [DIV_QW];
  logic              v_div [DIV_QW];
  div_side_t         dside [DIV_QW];

  genvar gk;
  generate
    for (gk = 0; gk < DIV_QW; gk++) begin : g_div
      if (gk == 0) begin : g_first
        uvs_div_cell u_cell_r (
          .clk(clk), .en(adv),
          .rem_in({2'b00, r0[7:1]}), .q_in('0), .nbit(r0[0]), .dvsr(d_r),
          .rem_out(rem_r[gk]), .q_out(quo_r[gk])
        );
        uvs_div_cell u_cell_s (
          .clk(clk), .en(adv),
          .rem_in({2'b00, s0[7:1]}), .q_in('0), .nbit(s0[0]), .dvsr(d_s),
          .rem_out(rem_s[gk]), .q_out(quo_s[gk])
        );
      end else begin : g_rest
        uvs_div_cell u_cell_r (
          .clk(clk), .en(adv),
          .rem_in(rem_r[gk-1]), .q_in(quo_r[gk-1]), .nbit(1'b0), .dvsr(d_r),
          .rem_out(rem_r[gk]), .q_out(quo_r[gk])
        );
        uvs_div_cell u_cell_s (
          .clk(clk), .en(adv),
          .rem_in(rem_s[gk-1]), .q_in(quo_s[gk-1]), .nbit(1'b0), .dvsr(d_s),
          .rem_out(rem_s[gk]), .q_out(quo_s[gk])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_QW; k++) v_div[k] <= 1'b0;
    end else if (adv) begin
      v_div[0] <= v_in;
      for (int k = 1; k < DIV_QW; k++) v_div[k] <= v_div[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside[0] <= side0;
      for (int k = 1; k < DIV_QW; k++) dside[k] <= dside[k-1];
    end
  end

  // ---------------- angle stage ----------------
  // ath = round(r * 2^31 / d), aph = round(s * 2^32 / d) mod 2^32,
  // texture = round(x * 2^15 / d); all come out of F by shifts.
  logic [DIV_QW-1:0]   f_r;
  logic [DIV_QW-1:0]   f_s;
  logic [31:0]         ath;
  logic [31:0]         aph;
  logic [31:0]         b_th;
  logic [31:0]         b_ph;
  logic signed [30:0]  off_th;
  logic signed [30:0]  off_ph;
  side_t               sideA_next;
  logic signed [62:0]  prod_th;
  logic signed [62:0]  prod_ph;
  side_t               sideA;
  logic                vA;

  always_comb begin
    f_r    = quo_r[DIV_QW-1];
    f_s    = quo_s[DIV_QW-1];
    ath    = 32'(((f_r >> 1) + 34'd1) >> 1);
    aph    = 32'((f_s + 34'd1) >> 1);
    b_th   = ath + QTR_OFFSET;
    b_ph   = aph + QTR_OFFSET;
    off_th = $signed({1'b0, b_th[29:0]}) - 31'sh2000_0000;
    off_ph = $signed({1'b0, b_ph[29:0]}) - 31'sh2000_0000;
    sideA_next.quad_base  = dside[DIV_QW-1].quad_base;
    sideA_next.quad_valid = dside[DIV_QW-1].quad_valid;
    sideA_next.tex_v      = 16'(((f_r >> 17) + 34'd1) >> 1);
    sideA_next.tex_u      = 16'(((f_s >> 17) + 34'd1) >> 1);
    sideA_next.q_th       = b_th[31:30];
    sideA_next.q_ph       = b_ph[31:30];
  end

  always_ff @(posedge clk) begin
    if (rst) vA <= 1'b0;
    else if (adv) vA <= v_div[DIV_QW-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_th <= 63'(off_th) * 63'(HALF_PI_Q30);
      prod_ph <= 63'(off_ph) * 63'(HALF_PI_Q30);
      sideA   <= sideA_next;
    end
  end

  // ---------------- CORDIC chains ----------------
  logic signed [CW-1:0] z0_th;
  logic signed [CW-1:0] z0_ph;
  logic signed [CW-1:0] xt [CORDIC_STEPS];
  logic signed [CW-1:0] yt [CORDIC_STEPS];
  logic signed [CW-1:0] zt [CORDIC_STEPS];
  logic signed [CW-1:0] xp [CORDIC_STEPS];
  logic signed [CW-1:0] yp [CORDIC_STEPS];
  logic signed [CW-1:0] zp [CORDIC_STEPS];
  logic                 v_cor [CORDIC_STEPS];
  side_t                cside [CORDIC_STEPS];

  assign z0_th = CW'(shr_round(68'(prod_th), 30));
  assign z0_ph = CW'(shr_round(68'(prod_ph), 30));

  generate
    for (gk = 0; gk < CORDIC_STEPS; gk++) begin : g_cor
      if (gk == 0) begin : g_first
        uvs_cordic_cell #(.STEP(gk)) u_th (
          .clk(clk), .en(adv), .x_in(CORDIC_K), .y_in('0), .z_in(z0_th),
          .x_out(xt[gk]), .y_out(yt[gk]), .z_out(zt[gk])
        );
        uvs_cordic_cell #(.STEP(gk)) u_ph (
          .clk(clk), .en(adv), .x_in(CORDIC_K), .y_in('0), .z_in(z0_ph),
          .x_out(xp[gk]), .y_out(yp[gk]), .z_out(zp[gk])
        );
      end else begin : g_rest
        uvs_cordic_cell #(.STEP(gk)) u_th (
          .clk(clk), .en(adv), .x_in(xt[gk-1]), .y_in(yt[gk-1]), .z_in(zt[gk-1]),
          .x_out(xt[gk]), .y_out(yt[gk]), .z_out(zt[gk])
        );
        uvs_cordic_cell #(.STEP(gk)) u_ph (
          .clk(clk), .en(adv), .x_in(xp[gk-1]), .y_in(yp[gk-1]), .z_in(zp[gk-1]),
          .x_out(xp[gk]), .y_out(yp[gk]), .z_out(zp[gk])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CORDIC_STEPS; k++) v_cor[k] <= 1'b0;
    end else if (adv) begin
      v_cor[0] <= vA;
      for (int k = 1; k < CORDIC_STEPS; k++) v_cor[k] <= v_cor[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cside[0] <= sideA;
      for (int k = 1; k < CORDIC_STEPS; k++) cside[k] <= cside[k-1];
    end
  end

  // ---------------- quadrant map ----------------
  logic signed [CW-1:0] ct_next;
  logic signed [CW-1:0] st_next;
  logic signed [CW-1:0] cp_next;
  logic signed [CW-1:0] sp_next;
  logic signed [CW-1:0] ct;
  logic signed [CW-1:0] st;
  logic signed [CW-1:0] cp;
  logic signed [CW-1:0] sp;
  side_t                sideM;
  logic                 vM;

  always_comb begin
    case (cside[CORDIC_STEPS-1].q_th)
      QUAD_0: begin ct_next = xt[CORDIC_STEPS-1];  st_next = yt[CORDIC_STEPS-1];  end
      QUAD_1: begin ct_next = -yt[CORDIC_STEPS-1]; st_next = xt[CORDIC_STEPS-1];  end
      QUAD_2: begin ct_next = -xt[CORDIC_STEPS-1]; st_next = -yt[CORDIC_STEPS-1]; end
      default: begin ct_next = yt[CORDIC_STEPS-1]; st_next = -xt[CORDIC_STEPS-1]; end
    endcase
    case (cside[CORDIC_STEPS-1].q_ph)
      QUAD_0: begin cp_next = xp[CORDIC_STEPS-1];  sp_next = yp[CORDIC_STEPS-1];  end
      QUAD_1: begin cp_next = -yp[CORDIC_STEPS-1]; sp_next = xp[CORDIC_STEPS-1];  end
      QUAD_2: begin cp_next = -xp[CORDIC_STEPS-1]; sp_next = -yp[CORDIC_STEPS-1]; end
      default: begin cp_next = yp[CORDIC_STEPS-1]; sp_next = -xp[CORDIC_STEPS-1]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) vM <= 1'b0;
    else if (adv) vM <= v_cor[CORDIC_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ct    <= ct_next;
      st    <= st_next;
      cp    <= cp_next;
      sp    <= sp_next;
      sideM <= cside[CORDIC_STEPS-1];
    end
  end

  // ---------------- sin(theta) products ----------------
  logic signed [67:0]   p_x;
  logic signed [67:0]   p_z;
  logic signed [CW-1:0] ctP;
  side_t                sideP;
  logic                 vP;

  always_ff @(posedge clk) begin
    if (rst) vP <= 1'b0;
    else if (adv) vP <= vM;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_x   <= 68'(st) * 68'(cp);
      p_z   <= 68'(st) * 68'(sp);
      ctP   <= ct;
      sideP <= sideM;
    end
  end

  // ---------------- normal in Q2.30 ----------------
  logic signed [CW-1:0] n_val [3];
  side_t                sideN;
  logic                 vN;

  always_ff @(posedge clk) begin
    if (rst) vN <= 1'b0;
    else if (adv) vN <= vP;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_val[0] <= CW'(shr_round(p_x, 30));
      n_val[1] <= -ctP;
      n_val[2] <= CW'(shr_round(p_z, 30));
      sideN    <= sideP;
    end
  end

  // ---------------- normal rounding, position product ----------------
  logic signed [15:0] nq    [3];
  logic signed [67:0] pprod [3];
  side_t              sideQ;
  logic               vQ;

  always_ff @(posedge clk) begin
    if (rst) vQ <= 1'b0;
    else if (adv) vQ <= vN;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        nq[k]    <= 16'(sat(shr_round(68'(n_val[k]), 15), -68'sd32768, 68'sd32767));
        pprod[k] <= 68'(n_val[k]) * 68'($signed({1'b0, radius}));
      end
      sideQ <= sideN;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vQ;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      normal_x   <= nq[0];
      normal_y   <= nq[1];
      normal_z   <= nq[2];
      pos_x      <= 17'(sat(shr_round(pprod[0], 30), -68'sd65535, 68'sd65535));
      pos_y      <= 17'(sat(shr_round(pprod[1], 30), -68'sd65535, 68'sd65535));
      pos_z      <= 17'(sat(shr_round(pprod[2], 30), -68'sd65535, 68'sd65535));
      tex_u      <= sideQ.tex_u;
      tex_v      <= sideQ.tex_v;
      quad_base  <= sideQ.quad_base;
      quad_valid <= sideQ.quad_valid;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/uvs_div_cell.sv
`default_nettype none
module uvs_div_cell import uvs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [DIV_RW-1:0] rem_in,
  input  wire logic [DIV_QW-1:0] q_in,
  input  wire logic              nbit,
  input  wire logic [DIV_RW-1:0] dvsr,
  output logic      [DIV_RW-1:0] rem_out,
  output logic      [DIV_QW-1:0] q_out
);
  logic [DIV_RW:0] trial;
  logic            ge;

  // one restoring step: bring down a bit, subtract if it fits
  always_comb begin
    trial = {rem_in, nbit};
    ge    = trial >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? DIV_RW'(trial - {1'b0, dvsr}) : DIV_RW'(trial);
      q_out   <= {q_in[DIV_QW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/uvs_cordic_cell.sv
`default_nettype none
module uvs_cordic_cell import uvs_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] x_in,
  input  wire logic signed [CW-1:0] y_in,
  input  wire logic signed [CW-1:0] z_in,
  output logic signed      [CW-1:0] x_out,
  output logic signed      [CW-1:0] y_out,
  output logic signed      [CW-1:0] z_out
);
  localparam logic signed [CW-1:0] ANGLE = CW'(ATAN_TAB[STEP]);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[CW-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ANGLE;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ANGLE;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/uvs_checker.sv
`default_nettype none
module uvs_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] tex_u,
  input wire logic [15:0] tex_v,
  input wire logic        quad_valid
);
  // a stalled item stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled item dropped");

  // an existing quad never sits on the last row or column
  a_quad_tex: assert property (@(posedge clk) disable iff (rst)
    out_valid && quad_valid |-> (tex_u < 16'd32768) && (tex_v < 16'd32768))
    else $error("quad flagged on last ring or sector");

  // texture never exceeds 1.0
  a_tex_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tex_u <= 16'd32768) && (tex_v <= 16'd32768))
    else $error("texture coordinate above 1.0");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("item offered after reset");
endmodule

bind uv_sphere_vertex_generator_unit uvs_port_checker u_uvs_port_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .tex_u(tex_u), .tex_v(tex_v), .quad_valid(quad_valid)
);
`default_nettype wire
